### hdl/header_length_tail_deframer_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the header/length/tail deframer.
// Each macro builds one labeled concurrent assertion on the rising clock edge,
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef HEADER_LENGTH_TAIL_DEFRAMER_DEFINES_SVH
`define HEADER_LENGTH_TAIL_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLTD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HLTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### hdl/hltd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hltd_pkg
// Shared constants, the result record type and the header byte lookup for the
// header/length/tail deframer.
// ---------------------------------------------------------------------------
package hltd_pkg;

  localparam logic [31:0] HDR_WORD    = 32'hA5FF5AFF;
  localparam logic [31:0] TAIL_WORD   = 32'h5AFFA5FF;
  localparam logic [32:0] MIN_FRAME   = 33'd24;
  localparam logic [30:0] LEN_SLOT    = 31'd4;   // frame bytes 16..19 have count[32:2] == 4
  localparam logic [32:0] HDR_COUNT   = 33'd4;
  localparam logic [32:0] COUNT_MAX   = 33'h1FFFFFFFF;
  localparam logic [2:0]  WINDOW_FULL = 3'd4;
  localparam logic [1:0]  LAST_HDR_BEAT = 2'd3;
  localparam int          QUEUE_DEPTH = 4;

  // One queued result: either a whole header (expanded to four beats on the
  // way out) or a single frame byte.
  typedef struct packed {
    logic       is_header;
    logic [7:0] data;
    logic       last;
  } hltd_rec_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = HDR_WORD[31:24];
      2'd1:    b = HDR_WORD[23:16];
      2'd2:    b = HDR_WORD[15:8];
      default: b = HDR_WORD[7:0];
    endcase
    return b;
  endfunction

endpackage

### hdl/hltd_core.sv
`timescale 1ns / 1ps
`include "header_length_tail_deframer_defines.svh"
// ---------------------------------------------------------------------------
// hltd_core
// Input register and frame tracking: byte window, header and tail detection,
// length capture and frame byte count. Emits at most one record per cycle.
// ---------------------------------------------------------------------------
module hltd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  output logic              pending,
  output logic              push,
  output hltd_pkg::hltd_rec_t rec
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [31:0] byte_window;
  logic [2:0]  window_fill;
  logic        in_frame;
  logic [32:0] frame_count;
  logic [31:0] length_field;

  logic [31:0] window_next;
  logic [2:0]  fill_next;
  logic [32:0] count_next;
  logic [31:0] length_next;
  logic [32:0] expected;
  logic        hdr_hit;
  logic        done;

  always_comb begin
    window_next = {byte_window[23:0], in_byte_q};
    fill_next   = (window_fill == hltd_pkg::WINDOW_FULL) ? window_fill : window_fill + 3'd1;
    hdr_hit     = !in_frame && (fill_next == hltd_pkg::WINDOW_FULL) &&
                  (window_next == hltd_pkg::HDR_WORD);
    count_next  = (frame_count == hltd_pkg::COUNT_MAX) ? frame_count : frame_count + 33'd1;
    length_next = length_field;
    if (frame_count[32:2] == hltd_pkg::LEN_SLOT) begin
      length_next[{frame_count[1:0], 3'b000} +: 8] = in_byte_q;
    end
    // The stored length is enough here: while the length bytes are still
    // arriving the count is below the minimum frame size anyway.
    expected = {1'b0, length_field} + hltd_pkg::MIN_FRAME;
    done     = in_frame && (count_next >= expected) && (window_next == hltd_pkg::TAIL_WORD);
  end

  assign pending       = in_valid_q;
  assign push          = in_valid_q && (hdr_hit || in_frame);
  assign rec.is_header = hdr_hit;
  assign rec.data      = in_byte_q;
  assign rec.last      = done;

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_q <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q   <= 1'b0;
      byte_window  <= '0;
      window_fill  <= '0;
      in_frame     <= 1'b0;
      frame_count  <= '0;
      length_field <= '0;
    end else begin
      in_valid_q <= accept;
      if (in_valid_q) begin
        if (done) begin
          byte_window  <= '0;
          window_fill  <= '0;
          in_frame     <= 1'b0;
          frame_count  <= '0;
          length_field <= '0;
        end else begin
          byte_window <= window_next;
          if (!in_frame) begin
            window_fill <= fill_next;
            if (hdr_hit) begin
              in_frame     <= 1'b1;
              frame_count  <= hltd_pkg::HDR_COUNT;
              length_field <= '0;
            end
          end else begin
            frame_count  <= count_next;
            length_field <= length_next;
          end
        end
      end
    end
  end

  `HLTD_ASSERT_NEXT(a_hdr_enters_frame, clk, rst, push && rec.is_header, in_frame && (frame_count == hltd_pkg::HDR_COUNT))
  `HLTD_ASSERT_NEXT(a_last_restarts_hunt, clk, rst, push && rec.last, !in_frame && (window_fill == 3'd0))

endmodule

### hdl/hltd_queue.sv
`timescale 1ns / 1ps
`include "header_length_tail_deframer_defines.svh"
// ---------------------------------------------------------------------------
// hltd_queue
// Result queue between the frame tracker and the output port. A header record
// leaves as four beats, any other record as one.
// ---------------------------------------------------------------------------
module hltd_queue #(
  parameter int DEPTH = hltd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hltd_pkg::hltd_rec_t rec,
  input  logic                reserve,
  output logic                no_room,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                frame_first,
  output logic                frame_last
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  hltd_pkg::hltd_rec_t mem [DEPTH];
  hltd_pkg::hltd_rec_t head;
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic [1:0]      beat;
  logic            beat_end;
  logic            pop;

  assign head      = mem[rd_ptr];
  assign out_valid = (count != '0);
  assign beat_end  = !head.is_header || (beat == hltd_pkg::LAST_HDR_BEAT);
  assign pop       = out_valid && !out_stall && beat_end;

  assign out_byte    = head.is_header ? hltd_pkg::hdr_byte(beat) : head.data;
  assign frame_first = head.is_header && (beat == 2'd0);
  assign frame_last  = !head.is_header && head.last;

  // The byte sitting in the tracker's input register always gets a slot.
  assign no_room = ({1'b0, count} + (CntW + 1)'(reserve)) >= (CntW + 1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      beat   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
      if (out_valid && !out_stall) begin
        beat <= beat_end ? 2'd0 : beat + 2'd1;
      end
    end
  end

  `HLTD_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CntW'(DEPTH))
  `HLTD_ASSERT_SAME(a_push_has_slot, clk, rst, push, count < CntW'(DEPTH))

endmodule

### hdl/header_length_tail_deframer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// header_length_tail_deframer
// Cuts frames out of a byte stream: hunts for the A5 FF 5A FF header, passes
// frame bytes through and closes the frame on the first 5A FF A5 FF tail once
// 24 plus the little-endian length in frame bytes 16..19 have passed.
//
//   channel  valid      stall      payload
//   input    in_valid   in_stall   in_byte
//   output   out_valid  out_stall  out_byte, frame_first, frame_last
//
// One byte is accepted per cycle while in_stall is low. A byte inside a frame
// passes through the input register and the result queue on its way to the
// output; a completed header appears as four beats. in_stall rises when the
// result queue entries plus the byte in the input register reach QUEUE_DEPTH.
// Reset is synchronous and returns the block to hunting with an empty window.
// ---------------------------------------------------------------------------
module header_length_tail_deframer #(
  parameter int QUEUE_DEPTH = hltd_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       frame_first,
  output logic       frame_last
);

  logic                accept;
  logic                pending;
  logic                push;
  logic                no_room;
  hltd_pkg::hltd_rec_t rec;

  assign in_stall = no_room;
  assign accept   = in_valid && !no_room;

  hltd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .pending (pending),
    .push    (push),
    .rec     (rec)
  );

  hltd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .rec         (rec),
    .reserve     (pending),
    .no_room     (no_room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .frame_first (frame_first),
    .frame_last  (frame_last)
  );

endmodule
